// ===== hw/rtl/ebml_element_header_parser_defines.svh =====
// Assertion macros shared by the EBML header parser RTL.
// No dependencies.
`ifndef EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define EBML_ELEMENT_HEADER_PARSER_DEFINES_SVH
// Concurrent implication checked on every rising clock edge outside reset.
`define EHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define EHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/ehp_pkg.sv =====
// Shared types and constants for the EBML element header parser.
// No dependencies.
package ehp_pkg;
	localparam int unsigned EHP_MAX_DEPTH = 8;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_BAD_LEAD = 2'd1,
		KIND_TOO_DEEP = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [63:0] elem_code;
		logic [3:0]  code_bytes;
		logic [55:0] payload_len;
		logic [3:0]  len_bytes;
		logic [3:0]  nest_depth;
		logic        is_master;
	} rec_t;

	localparam logic [63:0] ID_EBML     = 64'h1A45DFA3;
	localparam logic [63:0] ID_SEGMENT  = 64'h18538067;
	localparam logic [63:0] ID_INFO     = 64'h1549A966;
	localparam logic [63:0] ID_TRACKS   = 64'h1654AE6B;
	localparam logic [63:0] ID_CLUSTER  = 64'h1F43B675;
	localparam logic [7:0]  LEAD_MARKER = 8'h80;

	// Length of a vint from its lead byte, 0 for a zero byte.
	function automatic logic [3:0] vint_len(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i] && n == 4'd0) begin
				n = 4'(8 - i);
			end
		end
		return n;
	endfunction

	function automatic logic is_container(input logic [63:0] id);
		return id == ID_EBML || id == ID_SEGMENT || id == ID_INFO ||
			id == ID_TRACKS || id == ID_CLUSTER;
	endfunction
endpackage

// ===== hw/rtl/ehp_byte_if.sv =====
// Valid/ready channel interfaces for the EBML header parser.
// No dependencies.
interface ehp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, data_byte, input ready);
	modport sink (input valid, data_byte, output ready);
endinterface

interface ehp_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_kind;
	logic [63:0] elem_code;
	logic [3:0]  code_bytes;
	logic [55:0] payload_len;
	logic [3:0]  len_bytes;
	logic [3:0]  nest_depth;
	logic        is_master;
	modport source (output valid, record_kind, elem_code, code_bytes, payload_len,
		len_bytes, nest_depth, is_master, input ready);
	modport sink (input valid, record_kind, elem_code, code_bytes, payload_len,
		len_bytes, nest_depth, is_master, output ready);
endinterface

// ===== hw/rtl/ehp_front.sv =====
// Front: vint decoding, payload skip, nesting stack; one byte per cycle while step is high.
// Depends on ehp_pkg.
module ehp_front import ehp_pkg::*; #(
	parameter int unsigned MAX_DEPTH = EHP_MAX_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	output logic       rec_valid,
	output rec_t       rec
);
	localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [1:0] {ID_LEAD, ID_MORE, SIZE_LEAD, SIZE_MORE} phase_t;

	phase_t      phase_q;
	logic [63:0] acc_q, held_id_q, pos_q;
	logic [3:0]  left_q, idl_q, szl_q;
	logic [55:0] skip_q;
	logic [LW-1:0] open_q;
	logic [63:0] ends_q [MAX_DEPTH];

	logic [63:0] pos_n, acc_n, size64;
	logic [3:0]  len;
	logic        fin, master, push;
	logic [LW-1:0] open_mid, open_n;
	phase_t      phase_n;
	logic [3:0]  left_n;
	logic [55:0] skip_n;

	always_comb begin
		pos_n = pos_q + 64'd1;
		len = vint_len(data_byte);
		acc_n = acc_q;
		left_n = left_q;
		phase_n = phase_q;
		skip_n = skip_q;
		fin = 1'b0;
		rec_valid = 1'b0;
		rec = '0;
		rec.nest_depth = 4'(open_q);
		case (phase_q)
			ID_LEAD: begin
				if (skip_q != '0) begin
					skip_n = skip_q - 56'd1;
				end else if (len == 4'd0) begin
					rec_valid = 1'b1;
					rec.record_kind = KIND_BAD_LEAD;
				end else begin
					acc_n = {56'd0, data_byte};
					left_n = len - 4'd1;
					phase_n = (len == 4'd1) ? SIZE_LEAD : ID_MORE;
				end
			end
			ID_MORE: begin
				acc_n = {acc_q[55:0], data_byte};
				left_n = left_q - 4'd1;
				if (left_q == 4'd1) phase_n = SIZE_LEAD;
			end
			SIZE_LEAD: begin
				if (len == 4'd0) begin
					rec_valid = 1'b1;
					rec.record_kind = KIND_BAD_LEAD;
					phase_n = ID_LEAD;
				end else begin
					acc_n = {56'd0, data_byte & ~(LEAD_MARKER >> (len - 4'd1))};
					left_n = len - 4'd1;
					if (len == 4'd1) fin = 1'b1;
					else phase_n = SIZE_MORE;
				end
			end
			default: begin
				acc_n = {acc_q[55:0], data_byte};
				if (left_q != 4'd0) left_n = left_q - 4'd1;
				if (left_q <= 4'd1) fin = 1'b1;
			end
		endcase
		size64 = {8'd0, acc_n[55:0]};
		master = is_container(held_id_q);
		push = 1'b0;
		if (fin) begin
			phase_n = ID_LEAD;
			left_n = 4'd0;
			rec_valid = 1'b1;
			rec.elem_code = held_id_q;
			rec.payload_len = acc_n[55:0];
			rec.is_master = master;
			if (master && open_q >= LW'(MAX_DEPTH)) begin
				rec.record_kind = KIND_TOO_DEEP;
				skip_n = acc_n[55:0];
			end else begin
				rec.record_kind = KIND_HEADER;
				rec.code_bytes = idl_q;
				rec.len_bytes = (phase_q == SIZE_LEAD) ? len : szl_q;
				if (master) push = 1'b1;
				else skip_n = acc_n[55:0];
			end
		end
		open_mid = push ? open_q + LW'(1) : open_q;
		// lowest open level whose end has been reached closes it and all above
		open_n = open_mid;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			if (LW'(i) < open_mid) begin
				if ((push && LW'(i) == open_q) ? (pos_n + size64 <= pos_n)
					: (ends_q[i] <= pos_n)) open_n = LW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ID_LEAD;
			acc_q <= '0;
			held_id_q <= '0;
			pos_q <= '0;
			left_q <= '0;
			idl_q <= '0;
			szl_q <= '0;
			skip_q <= '0;
			open_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q <= acc_n;
			left_q <= left_n;
			skip_q <= skip_n;
			pos_q <= pos_n;
			open_q <= open_n;
			if (phase_q == ID_LEAD && skip_q == '0 && len != 4'd0) idl_q <= len;
			if (phase_q == SIZE_LEAD && len != 4'd0) szl_q <= len;
			if ((phase_q == ID_LEAD && phase_n == SIZE_LEAD) ||
				(phase_q == ID_MORE && left_q == 4'd1)) held_id_q <= acc_n;
		end
	end

	// end position counts the byte that completes the header
	always_ff @(posedge clk) begin
		if (step && push) ends_q[open_q[IW-1:0]] <= pos_n + size64;
	end
endmodule

// ===== hw/rtl/ehp_queue.sv =====
// Two-entry record queue between the front and the output channel.
// Depends on ehp_pkg.
module ehp_queue import ehp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic has_room,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_rec
);
	rec_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign out_rec = mem_q[rd_q];
	assign has_room = (cnt_q != 2'd2) || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end
endmodule

// ===== hw/rtl/ebml_element_header_parser.sv =====
// Top level of the EBML element header parser.
// Depends on ehp_pkg, ehp_byte_if, ehp_rec_if, ehp_front, ehp_queue, defines header.
//
//  channel   dir  payload                                   request
//  in_ch     in   data_byte[7:0]                            one stream byte
//  out_ch    out  record_kind..is_master (ehp_pkg::rec_t)    one header/error record
//
// One byte per cycle while the queue has room; a record is written into the
// queue when its last byte is accepted. The front step is combinational (vint
// shift, stack compare of all MAX_DEPTH ends in parallel); the 2-entry queue
// absorbs sink stalls and in_ch.ready drops only when the queue is full.
// arst_n clears all control state; the end-position stack needs no reset.
`include "ebml_element_header_parser_defines.svh"
module ebml_element_header_parser import ehp_pkg::*; #(
	parameter int unsigned MAX_DEPTH = EHP_MAX_DEPTH
) (
	input logic clk,
	input logic arst_n,
	ehp_byte_if.sink in_ch,
	ehp_rec_if.source out_ch
);
	logic step, front_valid, room;
	rec_t front_rec, q_rec;

	// accept a byte whenever the queue can take any record it may produce
	assign in_ch.ready = room;
	assign step = in_ch.valid && room;

	ehp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .step(step), .data_byte(in_ch.data_byte),
		.rec_valid(front_valid), .rec(front_rec)
	);

	ehp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(step && front_valid), .push_rec(front_rec),
		.has_room(room), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_rec(q_rec)
	);

	assign out_ch.record_kind = q_rec.record_kind;
	assign out_ch.elem_code = q_rec.elem_code;
	assign out_ch.code_bytes = q_rec.code_bytes;
	assign out_ch.payload_len = q_rec.payload_len;
	assign out_ch.len_bytes = q_rec.len_bytes;
	assign out_ch.nest_depth = q_rec.nest_depth;
	assign out_ch.is_master = q_rec.is_master;

	`EHP_ASSERT_IMPL(a_bad_lead_zero, clk, arst_n,
		out_ch.valid && out_ch.record_kind == KIND_BAD_LEAD,
		out_ch.elem_code == '0 && out_ch.code_bytes == '0, "bad lead record not cleared")
	`EHP_ASSERT_IMPL(a_deep_master, clk, arst_n,
		out_ch.valid && out_ch.record_kind == KIND_TOO_DEEP,
		out_ch.is_master && out_ch.nest_depth == 4'(MAX_DEPTH), "too-deep record mismatch")
	`EHP_ASSERT_NEXT(a_queue_hold, clk, arst_n,
		out_ch.valid && !out_ch.ready, out_ch.valid, "queued record lost")
endmodule
